@@ design/radio_admission_window_policy_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the admission window policy checker
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RADIO_ADMISSION_WINDOW_POLICY_TOP_ASSERT_SVH
`define RADIO_ADMISSION_WINDOW_POLICY_TOP_ASSERT_SVH

// same-cycle implication
`define RAWP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rawp check failed");

// next-cycle implication
`define RAWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rawp check failed");

`endif

@@ design/rawp_pkg.sv @@
// ----------------------------------------------------------------------------
// rawp_pkg
// Types and constants shared by the admission window policy modules.
// ----------------------------------------------------------------------------
package rawp_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_NO_CLIENT_TIMEOUT = 2'd0;
  localparam logic [IDX_W-1:0] REG_RETRY_INTERVAL    = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] NO_CLIENT_TIMEOUT_RST = 31'd60000;
  localparam logic [CFG_W-1:0] RETRY_INTERVAL_RST    = 31'd1000;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_CONFIRM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_CLOSING = 2'd1,
    MODE_CLOSED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_CLOSE     = 2'd1,
    ACT_ADVERTISE = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] now_ms;
    logic              link_drop;
    logic              client_connected;
    logic              adv_on;
  } in_word_t;

  typedef struct packed {
    action_t action;
    mode_t   mode;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] no_client_timeout_ms;
    logic [CFG_W-1:0] retry_interval_ms;
  } cfg_t;

  // wrap-safe deadline check: (now - deadline) read as signed is >= 0
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return ~diff[TIME_W-1];
  endfunction

endpackage

@@ design/radio_admission_window_policy_top.sv @@
// ----------------------------------------------------------------------------
// radio_admission_window_policy_top
// Admission window controller for a wireless link.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one operation word: begin, update
// tick or confirm-closed, stamped with now_ms. Output channel
// (out_valid/out_ready) returns exactly one result word per input word:
// the requested action and the policy mode after the step.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the window
// timeout (index 0) and retry interval (index 1); writes are always accepted.
// A word accepted goes through the input register, then the single-step update
// into the result register, which shows it. Throughput: one word per cycle
// unless stalled; the policy state updates as each word moves into the result
// register, so consecutive words see each other's effects. When the receiver
// stalls, the result register holds and the input register fills; the input
// stays ready while a held word can move on.
// Reset: synchronous; mode goes to closed, time stamps and the connected flag
// clear, registers return to 60000 ms and 1000 ms, both channels empty.
// ----------------------------------------------------------------------------
module radio_admission_window_policy_top (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rawp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rawp_pkg::CFG_W-1:0]  cfg_data,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [rawp_pkg::TIME_W-1:0] now_ms,
  input  logic                        link_drop,
  input  logic                        client_connected,
  input  logic                        adv_on,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  action,
  output logic [1:0]                  policy_mode
);

  rawp_pkg::cfg_t     cfg;
  rawp_pkg::in_word_t word_in;
  rawp_pkg::in_word_t word_q;
  rawp_pkg::result_t  result;
  rawp_pkg::result_t  result_q;
  logic               word_valid;
  logic               space;
  logic               fire;

  assign word_in.operation        = operation;
  assign word_in.now_ms           = now_ms;
  assign word_in.link_drop        = link_drop;
  assign word_in.client_connected = client_connected;
  assign word_in.adv_on           = adv_on;

  // a held word steps when the result register has room
  assign fire = word_valid & space;

  rawp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rawp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word_in    (word_in),
    .take       (fire),
    .word_valid (word_valid),
    .word_q     (word_q)
  );

  rawp_policy_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .word   (word_q),
    .cfg    (cfg),
    .result (result)
  );

  rawp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result_in (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign action      = result_q.action;
  assign policy_mode = result_q.mode;

endmodule

@@ design/rawp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rawp_cfg_regs
// Configuration register file: window timeout and retry interval.
// ----------------------------------------------------------------------------
module rawp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rawp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rawp_pkg::CFG_W-1:0]  cfg_data,
  output rawp_pkg::cfg_t              cfg
);

  // writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_client_timeout_ms <= rawp_pkg::NO_CLIENT_TIMEOUT_RST;
      cfg.retry_interval_ms    <= rawp_pkg::RETRY_INTERVAL_RST;
    end else if (cfg_valid) begin
      if (cfg_index == rawp_pkg::REG_NO_CLIENT_TIMEOUT) begin
        cfg.no_client_timeout_ms <= cfg_data;
      end
      if (cfg_index == rawp_pkg::REG_RETRY_INTERVAL) begin
        cfg.retry_interval_ms <= cfg_data;
      end
    end
  end

endmodule

@@ design/rawp_in_stage.sv @@
// ----------------------------------------------------------------------------
// rawp_in_stage
// Input register: holds one operation word until the policy core takes it.
// ----------------------------------------------------------------------------
module rawp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rawp_pkg::in_word_t word_in,
  input  logic               take,
  output logic               word_valid,
  output rawp_pkg::in_word_t word_q
);

  // free when empty or when the held word leaves this cycle
  assign in_ready = ~word_valid | take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_q <= word_in;
    end
  end

endmodule

@@ design/rawp_policy_core.sv @@
// ----------------------------------------------------------------------------
// rawp_policy_core
// Policy state and the single-step next-state / action logic.
// ----------------------------------------------------------------------------
module rawp_policy_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  rawp_pkg::in_word_t   word,
  input  rawp_pkg::cfg_t       cfg,
  output rawp_pkg::result_t    result
);

  rawp_pkg::mode_t                 mode, mode_next;
  logic                            was_connected, was_connected_next;
  logic [rawp_pkg::TIME_W-1:0]     close_deadline, close_deadline_next;
  logic [rawp_pkg::TIME_W-1:0]     next_action_time, next_action_time_next;
  rawp_pkg::action_t               act;

  logic [rawp_pkg::TIME_W-1:0]     window_end;
  logic [rawp_pkg::TIME_W-1:0]     retry_time;
  logic                            fresh;
  logic                            close_hit;
  logic                            action_due;
  rawp_pkg::mode_t                 mode_mid;

  assign window_end = word.now_ms + {1'b0, cfg.no_client_timeout_ms};
  assign retry_time = word.now_ms + {1'b0, cfg.retry_interval_ms};

  // a disconnect, or a client that just went away, restarts the window
  assign fresh = word.link_drop | (~word.client_connected & was_connected);
  assign mode_mid = fresh ? rawp_pkg::MODE_OPEN : mode;

  // with a fresh window the deadline is now+timeout and the action time is now
  assign close_hit  = fresh ? (cfg.no_client_timeout_ms == '0)
                            : rawp_pkg::reached(word.now_ms, close_deadline);
  assign action_due = fresh | rawp_pkg::reached(word.now_ms, next_action_time);

  // next state and action
  always_comb begin
    mode_next             = mode;
    was_connected_next    = was_connected;
    close_deadline_next   = close_deadline;
    next_action_time_next = next_action_time;
    act                   = rawp_pkg::ACT_NONE;
    case (word.operation)
      rawp_pkg::OP_BEGIN: begin
        mode_next             = rawp_pkg::MODE_OPEN;
        was_connected_next    = 1'b0;
        close_deadline_next   = window_end;
        next_action_time_next = word.now_ms;
      end
      rawp_pkg::OP_UPDATE: begin
        if (mode == rawp_pkg::MODE_CLOSED) begin
          was_connected_next = 1'b0;
        end else begin
          if (fresh) begin
            close_deadline_next   = window_end;
            next_action_time_next = word.now_ms;
          end
          if (word.client_connected) begin
            mode_next          = rawp_pkg::MODE_OPEN;
            was_connected_next = 1'b1;
          end else begin
            was_connected_next = 1'b0;
            if (mode_mid == rawp_pkg::MODE_OPEN && close_hit) begin
              // window expired: the first close request goes out at once
              mode_next             = rawp_pkg::MODE_CLOSING;
              next_action_time_next = retry_time;
              act                   = rawp_pkg::ACT_CLOSE;
            end else if (mode_mid == rawp_pkg::MODE_CLOSING) begin
              mode_next = rawp_pkg::MODE_CLOSING;
              if (action_due) begin
                next_action_time_next = retry_time;
                act                   = rawp_pkg::ACT_CLOSE;
              end
            end else begin
              mode_next = rawp_pkg::MODE_OPEN;
              if (!word.adv_on && action_due) begin
                next_action_time_next = retry_time;
                act                   = rawp_pkg::ACT_ADVERTISE;
              end
            end
          end
        end
      end
      rawp_pkg::OP_CONFIRM: begin
        if (mode == rawp_pkg::MODE_CLOSING) begin
          mode_next = rawp_pkg::MODE_CLOSED;
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  assign result.action = act;
  assign result.mode   = mode_next;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= rawp_pkg::MODE_CLOSED;
      was_connected <= 1'b0;
    end else if (fire) begin
      mode          <= mode_next;
      was_connected <= was_connected_next;
    end
  end

  // time stamps
  always_ff @(posedge clk) begin
    if (rst) begin
      close_deadline   <= '0;
      next_action_time <= '0;
    end else if (fire) begin
      close_deadline   <= close_deadline_next;
      next_action_time <= next_action_time_next;
    end
  end

endmodule

@@ design/rawp_out_stage.sv @@
// ----------------------------------------------------------------------------
// rawp_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rawp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rawp_pkg::result_t   result_in,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output rawp_pkg::result_t   result_q
);

  // a new word may enter when empty or when the held one is taken
  assign space = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

@@ design/rawp_checker.sv @@
// ----------------------------------------------------------------------------
// rawp_checker
// Port-level checks on the admission window policy, bound to the top level.
// ----------------------------------------------------------------------------
`include "radio_admission_window_policy_top_assert.svh"

module rawp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] action,
  input logic [1:0] policy_mode
);

  // a stalled result word holds
  `RAWP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action) && $stable(policy_mode))

  // a close request only comes with the closing mode
  `RAWP_ASSERT_NOW(a_close_mode, out_valid && action == rawp_pkg::ACT_CLOSE, policy_mode == rawp_pkg::MODE_CLOSING)

  // an advertise request only comes with the open mode
  `RAWP_ASSERT_NOW(a_adv_mode, out_valid && action == rawp_pkg::ACT_ADVERTISE, policy_mode == rawp_pkg::MODE_OPEN)

  // no result word right after reset
  `RAWP_ASSERT_NOW(a_empty_after_rst, $past(rst), !out_valid)

endmodule

bind radio_admission_window_policy_top rawp_checker u_rawp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .action      (action),
  .policy_mode (policy_mode)
);
